FILE: sv/orp_pkg.sv
package orp_pkg;

	localparam int ORP_KEY_W            = 40;
	localparam int ORP_BYTES_W          = 40;
	localparam int ORP_TOTAL_W          = 46;
	localparam int ORP_LIMIT_W          = 7;
	localparam int ORP_OUT_IDX_W        = 6;
	// index slot in a cell, wide enough for the largest supported list
	localparam int ORP_IDX_W            = 8;
	localparam int ORP_MAX_RESULTS      = 64;
	localparam int ORP_DEF_MAX_SEGMENTS = 64;
	localparam int ORP_CFG_IDX_W        = 2;
	localparam int ORP_CFG_DATA_W       = ORP_TOTAL_W;
	localparam logic [ORP_LIMIT_W-1:0] ORP_CAP_RESET = ORP_LIMIT_W'(ORP_MAX_RESULTS);

	localparam logic [ORP_CFG_IDX_W-1:0] REG_BYTE_LIMIT      = 2'd0;
	localparam logic [ORP_CFG_IDX_W-1:0] REG_FILE_LIMIT      = 2'd1;
	localparam logic [ORP_CFG_IDX_W-1:0] REG_DELETE_CAPACITY = 2'd2;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PLAN,
		ST_OVF
	} state_t;

	typedef struct packed {
		logic [ORP_KEY_W-1:0]   key;
		logic [ORP_BYTES_W-1:0] bytes;
		logic                   locked;
		logic [ORP_IDX_W-1:0]   idx;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

FILE: sv/oldest_first_retention_planner_unit.sv
// oldest-first retention planner
// input channel (in_valid/in_ready): one beat per recorded segment, carrying
// its age key, byte size, locked flag and a last_entry mark. while loading,
// one beat is taken every cycle; each beat is dropped into its sorted place
// in a chain of cells (one cell per segment) in the cycle it is accepted.
// the beat with last_entry set closes the list and starts the plan walk;
// in_ready stays low until the final beat of the plan sits in the output register
// output channel (out_valid/out_ready): one beat per segment to delete, in
// oldest-first order, with plan_done on the last one; an empty plan gives a
// single beat with delete_valid low, an overflowed list a single beat with
// overflow_error high.
// walk: while not stalled, the chain shifts toward the head once per cycle;
// a deletion beat passes through one pending slot, which holds each result
// until the next decision settles plan_done, before the output register; an
// empty-plan or overflow beat is registered straight from the decision.
// a stalled receiver halts the walk at the next unlocked entry once the
// pending slot and the output register are both full; nothing is dropped.
// reset empties the chain, clears counters and sets delete_capacity to 64,
// byte_limit and file_limit to zero.
module oldest_first_retention_planner_unit #(
	parameter int MAX_SEGMENTS = orp_pkg::ORP_DEF_MAX_SEGMENTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [orp_pkg::ORP_CFG_IDX_W-1:0]    cfg_index,
	input  logic [orp_pkg::ORP_CFG_DATA_W-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [orp_pkg::ORP_KEY_W-1:0]        age_key,
	input  logic [orp_pkg::ORP_BYTES_W-1:0]      size_bytes,
	input  logic                                 is_locked,
	input  logic                                 last_entry,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [orp_pkg::ORP_OUT_IDX_W-1:0]    delete_index,
	output logic                                 delete_valid,
	output logic                                 overflow_error,
	output logic                                 plan_done
);
	import orp_pkg::*;

	// count must hold MAX_SEGMENTS itself
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int CMPW = (CW > ORP_LIMIT_W) ? CW : ORP_LIMIT_W;

	// configuration registers
	logic [ORP_TOTAL_W-1:0] byte_limit_q;
	logic [ORP_LIMIT_W-1:0] file_limit_q;
	logic [ORP_LIMIT_W-1:0] capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q <= '0;
			file_limit_q <= '0;
			capacity_q   <= ORP_CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BYTE_LIMIT:      byte_limit_q <= cfg_data;
				REG_FILE_LIMIT:      file_limit_q <= cfg_data[ORP_LIMIT_W-1:0];
				REG_DELETE_CAPACITY: capacity_q   <= cfg_data[ORP_LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// control state
	state_t                 state_q, state_d;
	logic [CW-1:0]          count_q, count_d;      // entries loaded, then kept
	logic [ORP_TOTAL_W-1:0] total_q, total_d;      // bytes loaded, then kept
	logic                   ovf_q, ovf_d;
	logic [ORP_LIMIT_W-1:0] n_q, n_d;              // deletions reported so far
	logic                   pend_valid_q, pend_valid_d;
	logic [ORP_OUT_IDX_W-1:0] pend_idx_q, pend_idx_d;

	// output register
	logic                     out_valid_q, out_valid_d;
	logic [ORP_OUT_IDX_W-1:0] out_idx_q, out_idx_d;
	logic                     out_dv_q, out_dv_d;
	logic                     out_ovf_q, out_ovf_d;
	logic                     out_done_q, out_done_d;

	// cell chain
	cell_ctrl_t ctrl;
	entry_t     new_entry;
	logic   [MAX_SEGMENTS-1:0] cell_valid;
	entry_t [MAX_SEGMENTS-1:0] cell_entry;
	logic   [MAX_SEGMENTS-1:0] cell_ins;

	assign new_entry.key    = age_key;
	assign new_entry.bytes  = size_bytes;
	assign new_entry.locked = is_locked;
	assign new_entry.idx    = ORP_IDX_W'(count_q);

	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
		logic   l_valid, l_ins, r_valid;
		entry_t l_entry, r_entry;
		if (g == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_entry = '0;
			assign l_ins   = 1'b0;
		end else begin : g_mid
			assign l_valid = cell_valid[g-1];
			assign l_entry = cell_entry[g-1];
			assign l_ins   = cell_ins[g-1];
		end
		if (g == MAX_SEGMENTS - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_entry = '0;
		end else begin : g_body
			assign r_valid = cell_valid[g+1];
			assign r_entry = cell_entry[g+1];
		end
		orp_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_entry   (new_entry),
			.left_valid  (l_valid),
			.left_entry  (l_entry),
			.left_ins    (l_ins),
			.right_valid (r_valid),
			.right_entry (r_entry),
			.valid       (cell_valid[g]),
			.entry       (cell_entry[g]),
			.ins         (cell_ins[g])
		);
	end

	// walk decision terms
	logic                   in_fire, full, out_free;
	logic                   head_valid;
	entry_t                 head;
	logic [ORP_LIMIT_W-1:0] cap;
	logic                   bytes_excess, count_excess, stop;
	logic [ORP_TOTAL_W:0]   sum_wide;
	logic [ORP_TOTAL_W-1:0] head_bytes;

	assign in_ready   = (state_q == ST_LOAD);
	assign in_fire    = in_valid && in_ready;
	assign full       = (count_q == CW'(MAX_SEGMENTS));
	assign out_free   = !out_valid_q || out_ready;
	assign head_valid = cell_valid[0];
	assign head       = cell_entry[0];
	assign head_bytes = ORP_TOTAL_W'(head.bytes);
	assign sum_wide   = {1'b0, total_q} + (ORP_TOTAL_W + 1)'(size_bytes);
	assign cap        = (capacity_q > ORP_LIMIT_W'(ORP_MAX_RESULTS))
		? ORP_LIMIT_W'(ORP_MAX_RESULTS) : capacity_q;
	assign bytes_excess = (byte_limit_q != '0) && (total_q > byte_limit_q);
	assign count_excess = (file_limit_q != '0)
		&& (CMPW'(count_q) > CMPW'(file_limit_q));
	// stop when the list is used up, only one segment remains, both limits
	// are met, or the capacity is reached
	assign stop = !head_valid || (count_q <= CW'(1)) || !(bytes_excess || count_excess)
		|| (n_q >= cap);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		total_d      = total_q;
		ovf_d        = ovf_q;
		n_d          = n_q;
		pend_valid_d = pend_valid_q;
		pend_idx_d   = pend_idx_q;
		out_valid_d  = out_valid_q && !out_ready;
		out_idx_d    = out_idx_q;
		out_dv_d     = out_dv_q;
		out_ovf_d    = out_ovf_q;
		out_done_d   = out_done_q;
		ctrl         = '0;

		case (state_q)
			ST_LOAD: begin
				if (in_fire) begin
					if (full) begin
						ovf_d = 1'b1;
					end else begin
						ctrl.insert = 1'b1;
						count_d     = count_q + CW'(1);
						total_d     = sum_wide[ORP_TOTAL_W] ? '1 : sum_wide[ORP_TOTAL_W-1:0];
					end
					if (last_entry) begin
						state_d = (ovf_q || full) ? ST_OVF : ST_PLAN;
					end
				end
			end
			ST_PLAN: begin
				if (stop) begin
					if (out_free) begin
						out_valid_d  = 1'b1;
						out_idx_d    = pend_valid_q ? pend_idx_q : '0;
						out_dv_d     = pend_valid_q;
						out_ovf_d    = 1'b0;
						out_done_d   = 1'b1;
						pend_valid_d = 1'b0;
						count_d      = '0;
						total_d      = '0;
						n_d          = '0;
						ctrl.clear   = 1'b1;
						state_d      = ST_LOAD;
					end
				end else if (head.locked) begin
					// locked: skipped, still counts toward the limits
					ctrl.shift = 1'b1;
				end else if (!pend_valid_q || out_free) begin
					if (pend_valid_q) begin
						out_valid_d = 1'b1;
						out_idx_d   = pend_idx_q;
						out_dv_d    = 1'b1;
						out_ovf_d   = 1'b0;
						out_done_d  = 1'b0;
					end
					pend_valid_d = 1'b1;
					pend_idx_d   = head.idx[ORP_OUT_IDX_W-1:0];
					total_d      = (total_q >= head_bytes) ? total_q - head_bytes : '0;
					count_d      = count_q - CW'(1);
					n_d          = n_q + ORP_LIMIT_W'(1);
					ctrl.shift   = 1'b1;
				end
			end
			ST_OVF: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_idx_d   = '0;
					out_dv_d    = 1'b0;
					out_ovf_d   = 1'b1;
					out_done_d  = 1'b1;
					count_d     = '0;
					total_d     = '0;
					ovf_d       = 1'b0;
					ctrl.clear  = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			total_q      <= '0;
			ovf_q        <= 1'b0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			total_q      <= total_d;
			ovf_q        <= ovf_d;
			n_q          <= n_d;
			pend_valid_q <= pend_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_idx_q <= pend_idx_d;
		out_idx_q  <= out_idx_d;
		out_dv_q   <= out_dv_d;
		out_ovf_q  <= out_ovf_d;
		out_done_q <= out_done_d;
	end

	assign out_valid      = out_valid_q;
	assign delete_index   = out_idx_q;
	assign delete_valid   = out_dv_q;
	assign overflow_error = out_ovf_q;
	assign plan_done      = out_done_q;

endmodule

FILE: sv/orp_cell.sv
module orp_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  orp_pkg::cell_ctrl_t ctrl,
	input  orp_pkg::entry_t     new_entry,
	input  logic                left_valid,
	input  orp_pkg::entry_t     left_entry,
	input  logic                left_ins,
	input  logic                right_valid,
	input  orp_pkg::entry_t     right_entry,
	output logic                valid,
	output orp_pkg::entry_t     entry,
	output logic                ins
);
	import orp_pkg::*;

	logic   valid_q;
	entry_t entry_q;

	// new entry goes here or earlier: slot empty or holds a strictly newer key
	assign ins   = !valid_q || (new_entry.key < entry_q.key);
	assign valid = valid_q;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (left_ins) begin
				valid_q <= left_valid;
			end else if (ins) begin
				valid_q <= 1'b1;
			end
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (left_ins) begin
				entry_q <= left_entry;
			end else if (ins) begin
				entry_q <= new_entry;
			end
		end else if (ctrl.shift) begin
			entry_q <= right_entry;
		end
	end

endmodule

FILE: bench/orp_plan_checker.sv
module orp_plan_checker #(
	parameter int MAX_SEGMENTS = orp_pkg::ORP_DEF_MAX_SEGMENTS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [orp_pkg::ORP_CFG_IDX_W-1:0]  cfg_index,
	input  logic [orp_pkg::ORP_CFG_DATA_W-1:0] cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [orp_pkg::ORP_KEY_W-1:0]      age_key,
	input  logic [orp_pkg::ORP_BYTES_W-1:0]    size_bytes,
	input  logic                               is_locked,
	input  logic                               last_entry,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [orp_pkg::ORP_OUT_IDX_W-1:0]  delete_index,
	input  logic                               delete_valid,
	input  logic                               overflow_error,
	input  logic                               plan_done,
	output int                                 mismatch_count,
	output int                                 deletes_outstanding
);
	import orp_pkg::*;

	typedef struct packed {
		logic [ORP_OUT_IDX_W-1:0] del_index;
		logic                     del_valid;
		logic                     ovf;
		logic                     done;
	} deletion_t;

	deletion_t expected_deletes[$];

	// shadow of the segment list being loaded
	logic [ORP_KEY_W-1:0]   seg_key  [MAX_SEGMENTS];
	logic [ORP_BYTES_W-1:0] seg_size [MAX_SEGMENTS];
	logic                   seg_lock [MAX_SEGMENTS];
	int                     seg_rank [MAX_SEGMENTS];
	int                     seg_count;
	logic [ORP_TOTAL_W-1:0] byte_sum;
	logic                   list_overflow;

	logic [ORP_TOTAL_W-1:0] byte_lim;
	logic [ORP_LIMIT_W-1:0] file_lim;
	logic [ORP_LIMIT_W-1:0] del_cap;

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_count++;
		$display("mismatch: %s expected %0h got %0h", what, want, got);
	endtask

	task automatic queue_deletion(input int idx, input logic dv, input logic ovf);
		deletion_t d;
		d.del_index = ORP_OUT_IDX_W'(idx);
		d.del_valid = dv;
		d.ovf = ovf;
		d.done = 1'b0;
		expected_deletes.push_back(d);
	endtask

	task automatic plan_done_mark();
		deletion_t tail;
		tail = expected_deletes.pop_back();
		tail.done = 1'b1;
		expected_deletes.push_back(tail);
	endtask

	task automatic absorb_segment(input logic [ORP_KEY_W-1:0] key,
			input logic [ORP_BYTES_W-1:0] size, input logic lock);
		int j;
		logic [ORP_TOTAL_W:0] sum;
		if (seg_count >= MAX_SEGMENTS) begin
			list_overflow = 1'b1;
			return;
		end
		seg_key[seg_count] = key;
		seg_size[seg_count] = size;
		seg_lock[seg_count] = lock;
		// stable: only strictly newer keys move aside
		j = seg_count;
		while (j > 0 && key < seg_key[seg_rank[j-1]]) begin
			seg_rank[j] = seg_rank[j-1];
			j--;
		end
		seg_rank[j] = seg_count;
		seg_count++;
		sum = {1'b0, byte_sum} + (ORP_TOTAL_W+1)'(size);
		byte_sum = sum[ORP_TOTAL_W] ? '1 : sum[ORP_TOTAL_W-1:0];
	endtask

	task automatic plan_deletions();
		logic [ORP_TOTAL_W-1:0] remaining;
		int kept;
		int cap;
		int n;
		int s;
		logic over_b;
		logic over_f;
		deletion_t tail;
		remaining = byte_sum;
		kept = seg_count;
		cap = (int'(del_cap) > ORP_MAX_RESULTS) ? ORP_MAX_RESULTS : int'(del_cap);
		n = 0;
		for (int i = 0; i < seg_count; i++) begin
			s = seg_rank[i];
			over_b = (byte_lim != '0) && (remaining > byte_lim);
			over_f = (file_lim != '0) && (kept > int'(file_lim));
			if (kept <= 1 || !(over_b || over_f) || n >= cap) break;
			if (seg_lock[s]) continue;
			queue_deletion(s, 1'b1, 1'b0);
			n++;
			remaining = (remaining >= ORP_TOTAL_W'(seg_size[s])) ?
				remaining - ORP_TOTAL_W'(seg_size[s]) : '0;
			kept--;
		end
		if (n == 0) begin
			queue_deletion(0, 1'b0, 1'b0);
		end
		tail = expected_deletes.pop_back();
		tail.done = 1'b1;
		expected_deletes.push_back(tail);
	endtask

	task automatic check_deletion();
		deletion_t want;
		if (expected_deletes.size() == 0) begin
			report_mismatch("unexpected result beat, index", '0, 64'(delete_index));
			return;
		end
		want = expected_deletes.pop_front();
		if (delete_index !== want.del_index)
			report_mismatch("delete_index", 64'(want.del_index), 64'(delete_index));
		if (delete_valid !== want.del_valid)
			report_mismatch("delete_valid", 64'(want.del_valid), 64'(delete_valid));
		if (overflow_error !== want.ovf)
			report_mismatch("overflow_error", 64'(want.ovf), 64'(overflow_error));
		if (plan_done !== want.done)
			report_mismatch("plan_done", 64'(want.done), 64'(plan_done));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count = 0;
			byte_sum = '0;
			list_overflow = 1'b0;
			byte_lim = '0;
			file_lim = '0;
			del_cap = ORP_CAP_RESET;
			expected_deletes.delete();
			mismatch_count = 0;
			deletes_outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BYTE_LIMIT:      byte_lim = cfg_data;
					REG_FILE_LIMIT:      file_lim = cfg_data[ORP_LIMIT_W-1:0];
					REG_DELETE_CAPACITY: del_cap = cfg_data[ORP_LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) check_deletion();
			if (in_valid && in_ready) begin
				absorb_segment(age_key, size_bytes, is_locked);
				if (last_entry) begin
					if (list_overflow) begin
						queue_deletion(0, 1'b0, 1'b1);
						plan_done_mark();
					end else begin
						plan_deletions();
					end
					seg_count = 0;
					byte_sum = '0;
					list_overflow = 1'b0;
				end
			end
			deletes_outstanding = expected_deletes.size();
		end
	end

endmodule

FILE: bench/oldest_first_retention_planner_unit_tb.sv
module oldest_first_retention_planner_unit_tb;
	import orp_pkg::*;

	// index with no register behind it, writes must be ignored
	localparam logic [ORP_CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [ORP_TOTAL_W-1:0] ALL_ONES46 = '1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SMALL_ITEMS = 5;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ORP_CFG_IDX_W-1:0] cfg_index;
	logic [ORP_CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [ORP_KEY_W-1:0] age_key;
	logic [ORP_BYTES_W-1:0] size_bytes;
	logic is_locked;
	logic last_entry;
	logic out_valid;
	logic out_ready;
	logic [ORP_OUT_IDX_W-1:0] delete_index;
	logic delete_valid;
	logic overflow_error;
	logic plan_done;

	int mismatch_count;
	int deletes_outstanding;
	int cycle_count = 0;

	// idling odds in percent, per side
	int send_idle_pct = 37;
	int recv_idle_pct = 37;
	// receiver hold-off request: a new tag starts a stall, with hold_len giving its length
	int hold_len = 0;
	int hold_tag = 0;
	int phase_items;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	oldest_first_retention_planner_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.age_key        (age_key),
		.size_bytes     (size_bytes),
		.is_locked      (is_locked),
		.last_entry     (last_entry),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.delete_index   (delete_index),
		.delete_valid   (delete_valid),
		.overflow_error (overflow_error),
		.plan_done      (plan_done)
	);

	orp_plan_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.age_key             (age_key),
		.size_bytes          (size_bytes),
		.is_locked           (is_locked),
		.last_entry          (last_entry),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.delete_index        (delete_index),
		.delete_valid        (delete_valid),
		.overflow_error      (overflow_error),
		.plan_done           (plan_done),
		.mismatch_count      (mismatch_count),
		.deletes_outstanding (deletes_outstanding)
	);

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver side: random back-pressure plus the occasional long hold-off
	initial begin
		int seen_tag;
		int hold_left;
		seen_tag = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_tag != seen_tag) begin
				seen_tag = hold_tag;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [ORP_BYTES_W-1:0] rand40();
		return ORP_BYTES_W'({$urandom, $urandom});
	endfunction

	// register write, one cycle of cfg_we starting at a falling edge
	task automatic write_reg(input logic [ORP_CFG_IDX_W-1:0] idx,
			input logic [ORP_CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// block idle: every predicted beat delivered, then idles before returning
	task automatic drain_plans();
		while (deletes_outstanding != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// one input beat; entered and left at a falling edge, valid held until taken
	task automatic send_segment(input logic [ORP_KEY_W-1:0] key,
			input logic [ORP_BYTES_W-1:0] size, input logic lock, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		age_key = key;
		size_bytes = size;
		is_locked = lock;
		last_entry = last;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		@(negedge clk);
		in_valid = 1'b0;
		phase_items++;
	endtask

	// a list of random segments; narrow key range often, for equal-key ties
	task automatic send_random_list(input int len);
		logic [ORP_KEY_W-1:0] key;
		for (int i = 0; i < len; i++) begin
			key = ($urandom_range(2) == 0) ? ORP_KEY_W'($urandom_range(7)) : rand40();
			send_segment(key, rand40() >> $urandom_range(40), $urandom_range(4) == 0,
				i == len - 1);
		end
	endtask

	initial begin
		int len;
		int sel;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		age_key = '0;
		size_bytes = '0;
		is_locked = 1'b0;
		last_entry = 1'b0;
		phase_items = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// limits disabled after reset: empty plan
		send_segment('0, '1, 1'b0, 1'b0);
		send_segment('1, '0, 1'b0, 1'b1);

		// count limit with ties, a locked entry and field extremes
		drain_plans();
		write_reg(REG_FILE_LIMIT, ORP_CFG_DATA_W'(2));
		send_segment(40'd5, 40'd100, 1'b0, 1'b0);
		send_segment(40'd3, 40'd200, 1'b1, 1'b0);
		send_segment(40'd5, 40'd300, 1'b0, 1'b0);
		send_segment('0, '0, 1'b0, 1'b0);
		send_segment('1, '1, 1'b0, 1'b1);
		// single segment never goes
		send_segment(40'd7, 40'd9, 1'b0, 1'b1);

		// tiny byte limit: walk runs down to one remaining segment
		drain_plans();
		write_reg(REG_FILE_LIMIT, ORP_CFG_DATA_W'(0));
		write_reg(REG_BYTE_LIMIT, ORP_CFG_DATA_W'(1));
		send_segment(40'd40, 40'd11, 1'b0, 1'b0);
		send_segment(40'd30, 40'd22, 1'b0, 1'b0);
		send_segment(40'd20, 40'd33, 1'b0, 1'b0);
		send_segment(40'd10, 40'd44, 1'b0, 1'b1);

		// zero capacity: empty plan
		drain_plans();
		write_reg(REG_DELETE_CAPACITY, ORP_CFG_DATA_W'(0));
		send_random_list(3);

		// capacity of one cuts the walk short
		drain_plans();
		write_reg(REG_DELETE_CAPACITY, ORP_CFG_DATA_W'(1));
		write_reg(REG_FILE_LIMIT, ORP_CFG_DATA_W'(1));
		send_random_list(3);

		// masked writes, capacity beyond 64, spare index; all locked: empty plan
		drain_plans();
		write_reg(REG_FILE_LIMIT, {{(ORP_CFG_DATA_W-8){1'b1}}, 8'h81});
		write_reg(REG_DELETE_CAPACITY, ALL_ONES46);
		write_reg(REG_BYTE_LIMIT, ORP_CFG_DATA_W'(0));
		write_reg(REG_SPARE, {rand40(), 6'($urandom)});
		for (int i = 0; i < 4; i++) begin
			send_segment(rand40(), rand40(), 1'b1, i == 3);
		end

		// random phases, each with its own register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_plans();
			// one long stretch with no idling on either side
			send_idle_pct = (p == 5) ? 0 : 37;
			recv_idle_pct = (p == 5) ? 0 : 37;
			if (p == 3) begin
				// full list, nearly all of it deleted
				write_reg(REG_BYTE_LIMIT, ORP_CFG_DATA_W'(0));
				write_reg(REG_FILE_LIMIT, ORP_CFG_DATA_W'(1));
				write_reg(REG_DELETE_CAPACITY, ORP_CFG_DATA_W'(64));
			end else if (p == 7) begin
				// top limits: a full list keeps everything
				write_reg(REG_BYTE_LIMIT, ALL_ONES46);
				write_reg(REG_FILE_LIMIT, ORP_CFG_DATA_W'(64));
				write_reg(REG_DELETE_CAPACITY, ORP_CFG_DATA_W'(64));
			end else begin
				sel = $urandom_range(3);
				write_reg(REG_BYTE_LIMIT, (sel == 0) ? '0 :
					ORP_CFG_DATA_W'({$urandom, $urandom}) >> $urandom_range(46, 2));
				write_reg(REG_FILE_LIMIT, ORP_CFG_DATA_W'(($urandom_range(3) == 0) ? 0 :
					$urandom_range(6, 1)));
				write_reg(REG_DELETE_CAPACITY, ORP_CFG_DATA_W'(($urandom_range(4) == 0) ?
					$urandom_range(127) : $urandom_range(8, 1)));
			end
			// receiver stalls for a long while as the full list loads and the
			// sender keeps offering the next lists behind it
			if (p == 3) begin
				hold_len = 400;
				hold_tag++;
			end
			if (p == 3 || p == 7) send_random_list(64);
			// lists beyond the store raise the overflow beat
			if (p == 1) send_random_list(66);
			if (p == 6) send_random_list(65);
			phase_items = 0;
			while (phase_items < PHASE_SMALL_ITEMS) begin
				sel = $urandom_range(99);
				len = (sel < 70) ? $urandom_range(6, 1) :
					(sel < 95) ? $urandom_range(16, 7) : $urandom_range(40, 17);
				send_random_list(len);
			end
		end
		in_valid = 1'b0;

		while (deletes_outstanding != 0) @(negedge clk);
		repeat (24) @(negedge clk);
		if (mismatch_count == 0 && deletes_outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
